FILE: rtl/arpb_pkg.sv
package arpb_pkg;

  // fixed payload geometry
  localparam int unsigned PAYLOAD_SAMPLES = 16;
  localparam int unsigned POS_W = $clog2(PAYLOAD_SAMPLES);

  // defaults for the top level parameters
  localparam int unsigned DEF_NUM_PAYLOADS = 8;
  localparam int unsigned DEF_AVG_LENGTH = 50;

  // playout period base is the average divided by two to this power
  localparam int unsigned PERIOD_SHIFT = 4;

  // queue depths
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DAC_W = 10;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CFG_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_GAIN = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] TARGET_FILL_RESET = 8'd64;
  localparam logic [CFG_W-1:0] CORRECTION_GAIN_RESET = 8'd1;
  localparam logic [WORD_W-1:0] AVG_RESET = 16'hFFFF;
  localparam logic [WORD_W-1:0] PERIOD_RESET = 16'h7FFF;

  // request class decided by the front end
  typedef enum logic [1:0] {
    ITEM_TICK,
    ITEM_WRITE,
    ITEM_WRITE_LAST
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } cmd_head_t;

  typedef struct packed {
    logic [DAC_W-1:0]  dac;
    logic [WORD_W-1:0] fill;
  } result_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_RUN,
    BK_MUL,
    BK_SUM,
    BK_SCALE,
    BK_AVG
  } back_state_t;

endpackage

FILE: rtl/arpb_ram.sv
module arpb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/arpb_front.sv
module arpb_front
  import arpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                opcode,
  input  logic [SAMPLE_W-1:0] sample_value,
  output cmd_head_t           head,
  input  logic                take
);

  localparam int unsigned QW = $clog2(CMD_DEPTH);

  item_t                  slots [CMD_DEPTH];
  logic [QW-1:0]          wr_ptr;
  logic [QW-1:0]          rd_ptr;
  logic [QW:0]            count;
  logic [POS_W-1:0]       payload_pos;
  logic                   accept;
  logic                   do_take;
  item_t                  incoming;

  assign full    = (count == (QW+1)'(CMD_DEPTH));
  assign accept  = push && !full;
  assign do_take = take && (count != '0);

  // classify: ticks, plain writes and the write that closes a payload
  always_comb begin
    incoming.sample = sample_value;
    if (!opcode) begin
      incoming.kind = ITEM_TICK;
    end else if (payload_pos == POS_W'(PAYLOAD_SAMPLES - 1)) begin
      incoming.kind = ITEM_WRITE_LAST;
    end else begin
      incoming.kind = ITEM_WRITE;
    end
  end

  // payload position counts writes only
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_pos <= '0;
    end else if (accept && opcode) begin
      payload_pos <= payload_pos + 1'b1;
    end
  end

  // command queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= incoming;
    end
  end

  // command queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({accept, do_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

`ifndef NO_ASSERTIONS
  a_take_needs_head: assert property (@(posedge clk) disable iff (rst)
    take |-> (count != '0))
    else $error("back end took a request from an empty command queue");
`endif

endmodule

FILE: rtl/arpb_out_queue.sv
module arpb_out_queue
  import arpb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    almost_full,
  output logic    empty,
  input  logic    pop,
  output result_t head_data
);

  localparam int unsigned QW = $clog2(OUT_DEPTH);

  result_t        slots [OUT_DEPTH];
  logic [QW-1:0]  wr_ptr;
  logic [QW-1:0]  rd_ptr;
  logic [QW:0]    count;
  logic           do_pop;

  assign empty       = (count == '0);
  assign almost_full = (count >= (QW+1)'(OUT_DEPTH - 1));
  assign do_pop      = pop && !empty;
  assign head_data   = slots[rd_ptr];

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // result pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |-> (count < (QW+1)'(OUT_DEPTH)))
    else $error("result pushed into a full output queue");
`endif

endmodule

FILE: rtl/arpb_back.sv
module arpb_back
  import arpb_pkg::*;
#(
  parameter int unsigned NUM_PAYLOADS = DEF_NUM_PAYLOADS,
  parameter int unsigned AVG_LENGTH = DEF_AVG_LENGTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_head_t            head,
  output logic                 take,
  input  logic                 out_almost_full,
  output logic                 res_push,
  output result_t              res_data
);

  localparam int unsigned DEPTH = NUM_PAYLOADS * PAYLOAD_SAMPLES;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  // reciprocal of the average length, exact for all 16-bit dividends
  localparam int unsigned RECIP_SHIFT = WORD_W + $clog2(AVG_LENGTH);
  localparam int unsigned RECIP_MULT =
    ((1 << RECIP_SHIFT) + AVG_LENGTH - 1) / AVG_LENGTH;
  localparam int unsigned PROD_W = RECIP_SHIFT + WORD_W;

  back_state_t          state;
  back_state_t          state_next;
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [WORD_W-1:0]    fill;
  logic [WORD_W-1:0]    avg;
  logic [WORD_W-1:0]    period;
  logic [WORD_W-1:0]    tick_cnt;
  logic [WORD_W-1:0]    played;
  logic [CFG_W-1:0]     target_fill;
  logic [CFG_W-1:0]     correction_gain;
  logic [WORD_W-1:0]    prod_ticks;
  logic [WORD_W-1:0]    prod_corr;
  logic [WORD_W-1:0]    avg_div;
  logic [WORD_W-1:0]    ticks;
  logic [WORD_W-1:0]    ticks_div;
  logic                 pend_valid;
  logic [WORD_W-1:0]    pend_fill;
  logic                 is_tick;
  logic                 is_play;
  logic                 ram_we;
  logic                 ram_re;
  logic [SAMPLE_W-1:0]  ram_q;
  logic [WORD_W-1:0]    excess;
  logic [2*WORD_W-1:0]  mul_ticks;
  logic [WORD_W+CFG_W-1:0] mul_corr;
  logic [PROD_W-1:0]    mul_avg;
  logic [PROD_W-1:0]    mul_tdiv;

  // sample ring
  arpb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_ptr),
    .wr_data (head.item.sample),
    .rd_en   (ram_re),
    .rd_addr (rd_ptr),
    .rd_data (ram_q)
  );

  // payload update arithmetic, one multiplier deep per stage
  assign excess    = fill - {{(WORD_W-CFG_W){1'b0}}, target_fill};
  assign mul_ticks = (2*WORD_W)'(played) * (2*WORD_W)'(period);
  assign mul_corr  = (WORD_W+CFG_W)'(excess) * (WORD_W+CFG_W)'(correction_gain);
  assign mul_avg   = PROD_W'(avg) * PROD_W'(RECIP_MULT);
  assign mul_tdiv  = PROD_W'(ticks) * PROD_W'(RECIP_MULT);

  // sequencer: next state and request handling
  always_comb begin
    state_next = state;
    take       = 1'b0;
    is_tick    = (head.item.kind == ITEM_TICK);
    is_play    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state)
      BK_RUN: begin
        take = head.valid && (!is_tick || !out_almost_full);
        if (take) begin
          case (head.item.kind)
            ITEM_TICK: begin
              is_play = (tick_cnt == period);
              ram_re  = is_play;
            end
            ITEM_WRITE: begin
              ram_we = 1'b1;
            end
            ITEM_WRITE_LAST: begin
              ram_we     = 1'b1;
              state_next = BK_MUL;
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end
      end
      BK_MUL:   state_next = BK_SUM;
      BK_SUM:   state_next = BK_SCALE;
      BK_SCALE: state_next = BK_AVG;
      BK_AVG:   state_next = BK_RUN;
      default:  state_next = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_fill     <= TARGET_FILL_RESET;
      correction_gain <= CORRECTION_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_FILL:     target_fill <= cfg_data;
        REG_CORRECTION_GAIN: correction_gain <= cfg_data;
        default:             target_fill <= target_fill;
      endcase
    end
  end

  // playback state and payload update
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill       <= '0;
      avg        <= AVG_RESET;
      period     <= PERIOD_RESET;
      tick_cnt   <= '0;
      played     <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= is_play;
      case (state)
        BK_RUN: begin
          if (ram_we) begin
            wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
            fill   <= fill + 1'b1;
          end
          if (take && is_tick) begin
            if (is_play) begin
              tick_cnt <= '0;
              played   <= played + 1'b1;
              rd_ptr   <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
              fill     <= fill - 1'b1;
            end else begin
              tick_cnt <= tick_cnt + 1'b1;
            end
          end
        end
        BK_MUL: begin
          prod_ticks <= mul_ticks[WORD_W-1:0];
          prod_corr  <= mul_corr[WORD_W-1:0];
          avg_div    <= mul_avg[RECIP_SHIFT +: WORD_W];
        end
        BK_SUM: begin
          ticks    <= tick_cnt + prod_ticks;
          period   <= (avg >> PERIOD_SHIFT) - prod_corr;
          tick_cnt <= '0;
          played   <= '0;
        end
        BK_SCALE: begin
          ticks_div <= mul_tdiv[RECIP_SHIFT +: WORD_W];
        end
        BK_AVG: begin
          avg <= avg - avg_div + ticks_div;
        end
        default: begin
          avg <= avg;
        end
      endcase
    end
  end

  // fill after this playout travels with the memory read
  always_ff @(posedge clk) begin
    if (is_play) begin
      pend_fill <= fill - 1'b1;
    end
  end

  assign res_push      = pend_valid;
  assign res_data.dac  = ram_q[DAC_W-1:0];
  assign res_data.fill = pend_fill;

`ifndef NO_ASSERTIONS
  a_payload_starts_update: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN && take && head.item.kind == ITEM_WRITE_LAST) |=> (state == BK_MUL))
    else $error("payload close did not start the period update");

  a_no_take_while_updating: assert property (@(posedge clk) disable iff (rst)
    (state != BK_RUN) |-> !take)
    else $error("request taken during the period update");

  a_counters_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SUM) |=> (tick_cnt == '0 && played == '0))
    else $error("tick and played counters not cleared after payload");
`endif

endmodule

FILE: rtl/adaptive_rate_playback_buffer.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+--------------------------
// input     | in        | push / full               | opcode, sample_value
// result    | out       | pop / empty               | dac_sample, fill_level
// config    | in        | cfg_write (no wait)       | cfg_index, cfg_data
//
// one request per cycle in while full is low, one result per cycle out while empty is low; a
// playout passes the command queue, the registered memory read and the result queue
// the write closing a payload stalls the back end through MUL, SUM, SCALE and AVG (period and
// average update), so under back-to-back writes full rises once the 4-entry
// command queue has filled; ticks also wait there while the result queue is close to full
// rst is synchronous; no memory clearing pass is needed
module adaptive_rate_playback_buffer
  import arpb_pkg::*;
#(
  parameter int unsigned NUM_PAYLOADS = DEF_NUM_PAYLOADS,
  parameter int unsigned AVG_LENGTH = DEF_AVG_LENGTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 opcode,
  input  logic [SAMPLE_W-1:0]  sample_value,
  output logic                 empty,
  input  logic                 pop,
  output logic [DAC_W-1:0]     dac_sample,
  output logic signed [WORD_W-1:0] fill_level,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_head_t head;
  logic      take;
  logic      out_almost_full;
  logic      res_push;
  result_t   res_data;
  result_t   out_head;

  // accept and classify requests
  arpb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .sample_value (sample_value),
    .head         (head),
    .take         (take)
  );

  // carry out writes, ticks and payload updates
  arpb_back #(
    .NUM_PAYLOADS (NUM_PAYLOADS),
    .AVG_LENGTH   (AVG_LENGTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .head            (head),
    .take            (take),
    .out_almost_full (out_almost_full),
    .res_push        (res_push),
    .res_data        (res_data)
  );

  // results waiting to be popped
  arpb_out_queue u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (res_push),
    .push_data   (res_data),
    .almost_full (out_almost_full),
    .empty       (empty),
    .pop         (pop),
    .head_data   (out_head)
  );

  assign dac_sample = out_head.dac;
  assign fill_level = $signed(out_head.fill);

endmodule

FILE: tb/testbench.sv
module testbench;
  import arpb_pkg::*;

  localparam int unsigned STORE_DEPTH = DEF_NUM_PAYLOADS * PAYLOAD_SAMPLES;
  localparam int unsigned PTR_W = $clog2(STORE_DEPTH);

  // opcodes on the request port
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_GOAL = 1250;
  localparam int PLAYOUT_GOAL = 48;
  localparam int MAX_PHASES = 80;
  localparam int NEAR_TICKS = 64;
  localparam int DRAIN_TICKS = 600;

  localparam logic [15:0][SAMPLE_W-1:0] EDGE_SAMPLES = {
    16'h0000, 16'hFFFF, 16'h03FF, 16'hFC00, 16'h0400, 16'h7FFF, 16'h8000, 16'h0001,
    16'hFFFE, 16'hAAAA, 16'h5555, 16'h3C00, 16'h00FF, 16'hFF00, 16'h0200, 16'h1234
  };

  typedef struct {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    bit                  plays;
    result_t             playout;
  } request_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic                     opcode = OP_TICK;
  logic [SAMPLE_W-1:0]      sample_value = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [DAC_W-1:0]         dac_sample;
  logic signed [WORD_W-1:0] fill_level;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_TARGET_FILL;
  logic [CFG_W-1:0]         cfg_data = '0;

  adaptive_rate_playback_buffer dut (.*);

  // requests not yet taken by the block, playouts the block still owes
  request_t pending_requests[$];
  result_t  owed_playouts[$];

  int mismatches = 0;
  int requests_made = 0;
  int playouts_made = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int holds_asked = 0;
  int holds_done;
  int hold_left;

  // shadow of the playback buffer
  logic [SAMPLE_W-1:0] shadow_store [STORE_DEPTH];
  bit                  shadow_written [STORE_DEPTH];
  int                  slots_written = 0;
  logic [PTR_W-1:0]    shadow_wr, shadow_rd;
  logic [WORD_W-1:0]   shadow_fill, shadow_avg, shadow_period, shadow_ticks, shadow_played;
  logic [POS_W-1:0]    shadow_pos;
  logic [CFG_W-1:0]    shadow_target, shadow_gain;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // playout period chosen when a payload closes
  function automatic logic [WORD_W-1:0] retuned_period(logic [WORD_W-1:0] fill,
                                                       logic [CFG_W-1:0] tgt,
                                                       logic [CFG_W-1:0] gain,
                                                       logic [WORD_W-1:0] avg);
    logic [WORD_W-1:0] excess, corr;
    excess = fill - WORD_W'(tgt);
    corr = excess * WORD_W'(gain);
    return (avg >> PERIOD_SHIFT) - corr;
  endfunction

  // advance the shadow by one request and work out its playout
  task automatic advance_buffer(input logic op, input logic [SAMPLE_W-1:0] sample,
                                output bit plays, output result_t playout);
    logic [WORD_W-1:0] span;
    plays = 1'b0;
    playout = '0;
    if (op == OP_WRITE) begin
      if (!shadow_written[shadow_wr]) slots_written++;
      shadow_store[shadow_wr] = sample;
      shadow_written[shadow_wr] = 1'b1;
      shadow_wr++;
      shadow_fill++;
      shadow_pos++;
      // payload closed: measure, retune with the old average, then update it
      if (shadow_pos == 0) begin
        span = shadow_ticks + shadow_played * shadow_period;
        shadow_period = retuned_period(shadow_fill, shadow_target, shadow_gain, shadow_avg);
        shadow_played = '0;
        shadow_ticks = '0;
        shadow_avg = WORD_W'(shadow_avg - shadow_avg / DEF_AVG_LENGTH
                             + span / DEF_AVG_LENGTH);
      end
    end else if (shadow_ticks != shadow_period) begin
      shadow_ticks++;
    end else begin
      // playout tick, no guard against an empty buffer
      shadow_ticks = '0;
      shadow_played++;
      shadow_fill--;
      playout.dac = shadow_store[shadow_rd][DAC_W-1:0];
      playout.fill = shadow_fill;
      shadow_rd++;
      plays = 1'b1;
    end
  endtask

  task automatic offer(input logic op, input logic [SAMPLE_W-1:0] sample);
    request_t req;
    // never play out a slot that was never written
    if (op == OP_TICK && shadow_ticks == shadow_period && !shadow_written[shadow_rd])
      op = OP_WRITE;
    req.op = op;
    req.sample = sample;
    advance_buffer(op, sample, req.plays, req.playout);
    pending_requests.push_back(req);
    requests_made++;
    if (req.plays) playouts_made++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'h03FF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // settings that bring the period at the next payload close near the wanted value
  task automatic plan_settings(input int want_period,
                               output logic [CFG_W-1:0] tgt, output logic [CFG_W-1:0] gain);
    logic [WORD_W-1:0] fill_at_close, p;
    int best, gap;
    fill_at_close = WORD_W'(shadow_fill + (PAYLOAD_SAMPLES - shadow_pos));
    best = 1 << 30;
    tgt = TARGET_FILL_RESET;
    gain = CORRECTION_GAIN_RESET;
    for (int t = 0; t <= 128 && best != 0; t++) begin
      for (int g = 0; g < 256; g++) begin
        p = retuned_period(fill_at_close, CFG_W'(t), CFG_W'(g), shadow_avg);
        gap = (int'(p) > want_period) ? int'(p) - want_period : want_period - int'(p);
        if (gap < best) begin
          best = gap;
          tgt = CFG_W'(t);
          gain = CFG_W'(g);
        end
      end
    end
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] gain);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_TARGET_FILL;
    cfg_data <= tgt;
    @(posedge clk);
    cfg_index <= REG_CORRECTION_GAIN;
    cfg_data <= gain;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_target = tgt;
    shadow_gain = gain;
  endtask

  task automatic close_payload();
    do offer(OP_WRITE, random_sample());
    while (shadow_pos != 0);
  endtask

  // ticks dominate while a playout is near, writes otherwise
  task automatic mixed_requests(input int count);
    logic [WORD_W-1:0] distance;
    for (int i = 0; i < count; i++) begin
      distance = shadow_period - shadow_ticks;
      if ($urandom_range(99) < ((distance <= NEAR_TICKS) ? 75 : 15))
        offer(OP_TICK, random_sample());
      else
        offer(OP_WRITE, random_sample());
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || owed_playouts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (pending_requests[0].plays) owed_playouts.push_back(pending_requests[0].playout);
        pending_requests.delete(0);
      end
      if (push && full) begin
        // same request stays on offer
      end else if (pending_requests.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
        push <= 1'b1;
        opcode <= pending_requests[0].op;
        sample_value <= pending_requests[0].sample;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (holds_done != holds_asked) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_asked;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // playout monitor and checker
  always @(posedge clk) begin
    result_t owed;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (owed_playouts.size() == 0) begin
          $error("unexpected playout: dac_sample %0h fill_level %0d", dac_sample, fill_level);
          mismatches++;
        end else begin
          owed = owed_playouts.pop_front();
          if (dac_sample !== owed.dac) begin
            $error("dac_sample: expected %0h, got %0h", owed.dac, dac_sample);
            mismatches++;
          end
          if (fill_level !== owed.fill) begin
            $error("fill_level: expected %0d, got %0d", $signed(owed.fill), fill_level);
            mismatches++;
          end
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] tgt, gain;
    bit drain, held;
    int phase;
    held = 1'b0;
    shadow_wr = '0;
    shadow_rd = '0;
    shadow_fill = '0;
    shadow_avg = AVG_RESET;
    shadow_period = PERIOD_RESET;
    shadow_ticks = '0;
    shadow_played = '0;
    shadow_pos = '0;
    shadow_target = TARGET_FILL_RESET;
    shadow_gain = CORRECTION_GAIN_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: one payload of edge-case samples, then a few ticks
    for (int i = 0; i < 16; i++) offer(OP_WRITE, EDGE_SAMPLES[i]);
    repeat (4) offer(OP_TICK, 16'hFFFF);
    wait_drained();

    for (phase = 1;
         phase < MAX_PHASES && (requests_made < ITEM_GOAL || playouts_made < PLAYOUT_GOAL);
         phase++) begin
      // drain phases run the fill below zero once every slot holds a sample
      drain = (phase % 5 == 0) && (slots_written == STORE_DEPTH);
      case (phase)
        1: begin tgt = '0; gain = '0; end
        2: begin tgt = 8'd128; gain = 8'd255; end
        3: begin tgt = '0; gain = 8'd255; end
        4: begin tgt = 8'd128; gain = '0; end
        default: plan_settings(drain ? 0 : $urandom_range(24), tgt, gain);
      endcase
      write_settings(tgt, gain);

      // idling pattern rotates with the phase
      case (phase % 4)
        0: begin sender_gap_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_gap_pct = 64; receiver_stall_pct = 0; end
        2: begin sender_gap_pct = 0; receiver_stall_pct = 64; end
        default: begin sender_gap_pct = 18; receiver_stall_pct = 18; end
      endcase
      if (drain) begin
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
      end

      @(negedge clk);
      close_payload();
      if (drain) begin
        for (int i = 0; i < DRAIN_TICKS && $signed(shadow_fill) > -5; i++)
          offer(OP_TICK, random_sample());
        // first drain: receiver holds off while ticks keep coming
        if (!held) begin
          holds_asked++;
          held = 1'b1;
        end
      end else begin
        mixed_requests($urandom_range(48, 24));
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
